/* sv/ppls_pkg.sv */
// Package for the potentiometer paced LED scanner.
// Holds the beat payload types and fixed constants; no dependencies.
package ppls_pkg;

    localparam int SampleW = 10;
    localparam int CntW = 7;
    localparam logic [SampleW-1:0] VoltMax = 10'd1023;
    localparam logic [CntW-1:0] ReloadFull = 7'd100;
    localparam logic [SampleW-1:0] WindowReset = 10'd5;

    typedef struct packed {
        logic               command;
        logic [SampleW-1:0] sample_0;
        logic [SampleW-1:0] sample_1;
        logic [SampleW-1:0] sample_2;
        logic [SampleW-1:0] sample_3;
        logic [SampleW-1:0] sample_4;
        logic [SampleW-1:0] sample_5;
        logic [SampleW-1:0] sample_6;
        logic [SampleW-1:0] sample_7;
        logic [3:0]         release_events;
        logic [3:0]         press_events;
        logic               edge_select_switch;
    } t_item;

    typedef struct packed {
        logic [7:0]         led_pattern;
        logic               led_updated;
        logic [SampleW-1:0] filtered_voltage;
        logic               voltage_changed;
        logic               is_stopped;
    } t_result;

endpackage

/* sv/ppls_core.sv */
// Scanner state and per-beat update logic: averaging, hysteresis, tick pacing,
// stop toggle and the bouncing LED step. Depends on ppls_pkg.
module ppls_core #(
    parameter int LED_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  ppls_pkg::t_item   i_item,
    input  logic [9:0]        i_window,
    output ppls_pkg::t_result o_result
);
    import ppls_pkg::*;

    localparam int PadW = (LED_COUNT > 8) ? LED_COUNT : 8;
    localparam logic [LED_COUNT-1:0] LeftEnd = {1'b1, {(LED_COUNT-1){1'b0}}};
    localparam logic [LED_COUNT-1:0] RightEnd = {{(LED_COUNT-1){1'b0}}, 1'b1};

    logic [SampleW-1:0]   r_kept, n_kept;
    logic [CntW-1:0]      r_cnt, n_cnt;
    logic                 r_pending, n_pending;
    logic                 r_stop, n_stop;
    logic [LED_COUNT-1:0] r_lit, n_lit;
    logic                 r_right, n_right;
    logic [LED_COUNT-1:0] r_shown, n_shown;

    logic [12:0]          sum;
    logic [SampleW-1:0]   mean;
    logic [SampleW-1:0]   diff;
    logic                 changed;
    logic [16:0]          scaled;
    logic [CntW-1:0]      quot;
    logic [10:0]          rem;
    logic [CntW-1:0]      ceil_q;
    logic [CntW-1:0]      reload;
    logic [3:0]           events;
    logic                 updated;
    logic [PadW-1:0]      shown_pad;

    always_comb begin
        sum = 13'(i_item.sample_0) + 13'(i_item.sample_1) + 13'(i_item.sample_2)
            + 13'(i_item.sample_3) + 13'(i_item.sample_4) + 13'(i_item.sample_5)
            + 13'(i_item.sample_6) + 13'(i_item.sample_7);
        mean = sum[12:3];
        diff = (mean >= r_kept) ? (mean - r_kept) : (r_kept - mean);

        scaled = {1'b0, r_kept, 6'b0} + {2'b0, r_kept, 5'b0} + {5'b0, r_kept, 2'b0}
               + 17'd1022;
        quot = scaled[16:10];
        rem = {1'b0, scaled[9:0]} + 11'(quot);
        ceil_q = (rem >= 11'(VoltMax)) ? quot + 7'd1 : quot;
        reload = ReloadFull - ceil_q;

        events = i_item.edge_select_switch ? i_item.release_events : i_item.press_events;
    end

    always_comb begin
        n_kept = r_kept;
        n_cnt = r_cnt;
        n_pending = r_pending;
        n_stop = r_stop;
        n_lit = r_lit;
        n_right = r_right;
        n_shown = r_shown;
        changed = 1'b0;
        updated = 1'b0;

        if (i_item.command) begin
            if (diff >= i_window) begin
                changed = 1'b1;
                if (({1'b0, mean} + {1'b0, i_window}) >= {1'b0, VoltMax}) begin
                    n_kept = VoltMax;
                end else if (mean <= i_window) begin
                    n_kept = '0;
                end else begin
                    n_kept = mean;
                end
            end
        end else begin
            if (r_cnt <= 7'd1) begin
                n_cnt = reload;
                n_pending = 1'b1;
            end else begin
                n_cnt = r_cnt - 7'd1;
            end
            if (events != 4'd0) begin
                n_stop = !r_stop;
            end
        end

        if (n_pending && !n_stop) begin
            updated = 1'b1;
            n_shown = r_lit;
            n_pending = 1'b0;
            if (r_lit == LeftEnd) begin
                n_right = 1'b1;
            end else if (r_lit == RightEnd) begin
                n_right = 1'b0;
            end
            if (n_right) begin
                n_lit = r_lit >> 1;
            end else begin
                n_lit = {r_lit[LED_COUNT-2:0], 1'b0};
            end
            if (n_lit == '0) begin
                n_lit = RightEnd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept <= '0;
            r_cnt <= '0;
            r_pending <= 1'b0;
            r_stop <= 1'b0;
            r_lit <= RightEnd;
            r_right <= 1'b0;
            r_shown <= '0;
        end else if (i_en) begin
            r_kept <= n_kept;
            r_cnt <= n_cnt;
            r_pending <= n_pending;
            r_stop <= n_stop;
            r_lit <= n_lit;
            r_right <= n_right;
            r_shown <= n_shown;
        end
    end

    assign shown_pad = PadW'(n_shown);

    always_comb begin
        o_result.led_pattern = shown_pad[7:0];
        o_result.led_updated = updated;
        o_result.filtered_voltage = n_kept;
        o_result.voltage_changed = changed;
        o_result.is_stopped = n_stop;
    end

    a_lit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_lit))
        else $error("Lit position is not a single LED.");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ReloadFull)
        else $error("Tick countdown exceeds the full reload.");

    a_step_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && updated |=> !r_pending && !r_stop && (r_shown == $past(r_lit)))
        else $error("A step left the pending flag or pattern wrong.");

endmodule

/* sv/potentiometer_paced_led_scanner.sv */
// Top level of the potentiometer paced LED scanner.
// A beat accepted into the input register passes through ppls_core and is captured
// in the result register; one beat per cycle while the result channel is not stalled.
// An input register and a result register decouple the two channels.
// Synchronous active-low reset clears the valid flags and the core state, not the
// beat data registers; the window resets to 5. Depends on ppls_pkg and ppls_core.
module potentiometer_paced_led_scanner #(
    parameter int LED_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [9:0]        i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ppls_pkg::t_item   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ppls_pkg::t_result o_out_data
);
    import ppls_pkg::*;

    logic [SampleW-1:0] r_window;
    logic               r_in_valid;
    t_item              r_in;
    logic               r_out_valid;
    t_result            r_out;
    logic               advance;
    t_result            result;

    assign advance = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    ppls_core #(
        .LED_COUNT(LED_COUNT)
    ) u_core (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_en(advance),
        .i_item(r_in),
        .i_window(r_window),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WindowReset;
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule

/* tb/potentiometer_paced_led_scanner_tb.sv */
// Self-checking testbench for the potentiometer paced LED scanner.
// Directed and random beats are checked against table results or an in-bench model.
// Depends on ppls_pkg and potentiometer_paced_led_scanner.
module potentiometer_paced_led_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppls_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 170;
    localparam int HOLD_CYCLES = 64;
    localparam int PRINT_LIMIT = 20;
    localparam int PHASES = 6;
    localparam logic [7:0] RIGHT_END = 8'h01;
    localparam logic [7:0] LEFT_END = 8'h80;

    typedef struct {
        t_item   item;
        bit      typed;
        t_result want;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_we = 1'b0;
    logic [9:0] i_cfg_wdata = '0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_item     i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_result   o_out_data;

    bit        row_typed = 1'b0;
    t_result   row_want = '0;
    bit        hold_armed = 1'b0;
    bit        hold_done = 1'b0;
    bit        calm = 1'b0;

    t_result   scan_queue[$];
    int        beats_in = 0;
    int        beats_out = 0;
    int        errors = 0;
    int        cycle_count = 0;
    int        n_steps = 0;
    int        n_volt_changes = 0;
    int        n_frozen = 0;

    logic [9:0] mdl_window = WindowReset;
    logic [9:0] mdl_volt = '0;
    int         mdl_ticks_left = 0;
    bit         mdl_step_due = 1'b0;
    bit         mdl_frozen = 1'b0;
    logic [7:0] mdl_lamp = RIGHT_END;
    bit         mdl_heading_right = 1'b0;
    logic [7:0] mdl_shown = '0;

    potentiometer_paced_led_scanner i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d beats outstanding.",
                     cycle_count, beats_in - beats_out);
            $display("[potentiometer_paced_led_scanner] ERROR");
            $finish;
        end
    end

    task automatic flag_error(string msg);
        errors++;
        if (errors <= PRINT_LIMIT) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    function automatic t_result advance_scanner(t_item it);
        t_result r;
        int sum;
        int mean;
        int diff;
        int win;
        r = '0;
        win = int'(mdl_window);
        if (it.command) begin
            sum = int'(it.sample_0) + int'(it.sample_1) + int'(it.sample_2)
                + int'(it.sample_3) + int'(it.sample_4) + int'(it.sample_5)
                + int'(it.sample_6) + int'(it.sample_7);
            mean = sum / 8;
            diff = mean - int'(mdl_volt);
            if (diff < 0) begin
                diff = -diff;
            end
            if (diff >= win) begin
                r.voltage_changed = 1'b1;
                if (mean + win >= int'(VoltMax)) begin
                    mdl_volt = VoltMax;
                end else if (mean - win <= 0) begin
                    mdl_volt = '0;
                end else begin
                    mdl_volt = 10'(mean);
                end
            end
        end else begin
            mdl_ticks_left--;
            if (mdl_ticks_left <= 0) begin
                mdl_step_due = 1'b1;
                mdl_ticks_left = int'(ReloadFull)
                    - (int'(mdl_volt) * 100 + int'(VoltMax) - 1) / int'(VoltMax);
            end
            if ((it.edge_select_switch ? it.release_events : it.press_events) != 4'd0) begin
                mdl_frozen = !mdl_frozen;
            end
        end
        if (mdl_step_due && !mdl_frozen) begin
            mdl_shown = mdl_lamp;
            if (mdl_lamp == LEFT_END) begin
                mdl_heading_right = 1'b1;
            end else if (mdl_lamp == RIGHT_END) begin
                mdl_heading_right = 1'b0;
            end
            mdl_lamp = mdl_heading_right ? (mdl_lamp >> 1) : (mdl_lamp << 1);
            if (mdl_lamp == 8'h00) begin
                mdl_lamp = RIGHT_END;
            end
            mdl_step_due = 1'b0;
            r.led_updated = 1'b1;
        end
        r.led_pattern = mdl_shown;
        r.filtered_voltage = mdl_volt;
        r.is_stopped = mdl_frozen;
        return r;
    endfunction

    always @(posedge i_clk) begin : scan_monitor
        t_result got;
        t_result want;
        t_result guess;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                guess = advance_scanner(i_in_data);
                scan_queue.push_back(row_typed ? row_want : guess);
            end
            if (o_out_valid && i_out_ready) begin
                got = o_out_data;
                beats_out++;
                n_steps += got.led_updated;
                n_volt_changes += got.voltage_changed;
                n_frozen += got.is_stopped;
                if (scan_queue.size() == 0) begin
                    flag_error("Result beat arrived with nothing expected.");
                end else begin
                    want = scan_queue.pop_front();
                    if (got.led_pattern !== want.led_pattern)
                        flag_error($sformatf("led_pattern %h, expected %h",
                                             got.led_pattern, want.led_pattern));
                    if (got.led_updated !== want.led_updated)
                        flag_error($sformatf("led_updated %b, expected %b",
                                             got.led_updated, want.led_updated));
                    if (got.filtered_voltage !== want.filtered_voltage)
                        flag_error($sformatf("filtered_voltage %0d, expected %0d",
                                             got.filtered_voltage, want.filtered_voltage));
                    if (got.voltage_changed !== want.voltage_changed)
                        flag_error($sformatf("voltage_changed %b, expected %b",
                                             got.voltage_changed, want.voltage_changed));
                    if (got.is_stopped !== want.is_stopped)
                        flag_error($sformatf("is_stopped %b, expected %b",
                                             got.is_stopped, want.is_stopped));
                end
            end
        end
    end

    initial begin
        int hold_cycles;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_done) begin
                i_out_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++) begin
                    @(posedge i_clk);
                end
                hold_done = 1'b1;
                i_out_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic t_item adc_item(int s0, int s1, int s2, int s3,
                                       int s4, int s5, int s6, int s7);
        t_item it;
        it = '0;
        it.command = 1'b1;
        it.sample_0 = 10'(s0);
        it.sample_1 = 10'(s1);
        it.sample_2 = 10'(s2);
        it.sample_3 = 10'(s3);
        it.sample_4 = 10'(s4);
        it.sample_5 = 10'(s5);
        it.sample_6 = 10'(s6);
        it.sample_7 = 10'(s7);
        return it;
    endfunction

    function automatic t_item tick_item(logic [3:0] rel, logic [3:0] prs, logic sel);
        t_item it;
        it = '0;
        it.release_events = rel;
        it.press_events = prs;
        it.edge_select_switch = sel;
        return it;
    endfunction

    function automatic t_item random_item();
        t_item it;
        logic [95:0] noise;
        logic [9:0] s[8];
        int base;
        int amt;
        int v;
        noise = {$urandom, $urandom, $urandom};
        it = noise[$bits(t_item)-1:0];
        it.command = ($urandom_range(0, 9) < 3);
        if (it.command) begin
            amt = 8;
            case ($urandom_range(0, 3))
                0: base = $urandom_range(900, 1023);
                1: base = $urandom_range(0, 120);
                2: base = -1;
                default: begin
                    amt = 0;
                    base = int'(mdl_volt) + int'($urandom_range(0, 2 * int'(mdl_window)))
                         - int'(mdl_window);
                    if (base < 0) base = 0;
                    if (base > 1023) base = 1023;
                end
            endcase
            if (base >= 0) begin
                for (int i = 0; i < 8; i++) begin
                    v = base + int'($urandom_range(0, 2 * amt)) - amt;
                    if (v < 0) v = 0;
                    if (v > 1023) v = 1023;
                    s[i] = 10'(v);
                end
                it.sample_0 = s[0];
                it.sample_1 = s[1];
                it.sample_2 = s[2];
                it.sample_3 = s[3];
                it.sample_4 = s[4];
                it.sample_5 = s[5];
                it.sample_6 = s[6];
                it.sample_7 = s[7];
            end
        end else if ($urandom_range(0, 9) != 0) begin
            if (it.edge_select_switch) begin
                it.release_events = '0;
            end else begin
                it.press_events = '0;
            end
        end
        return it;
    endfunction

    task automatic offer(t_item it, bit typed, t_result want);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        row_typed <= typed;
        row_want <= want;
        do @(posedge i_clk); while (!o_in_ready);
        beats_in++;
    endtask

    task automatic sender_pause();
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic write_window(int w);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= 10'(w);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_window = 10'(w);
    endtask

    initial begin
        t_row rows[$];
        t_result none;
        int windows[PHASES];
        none = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, run with the window at its reset value.
        rows.push_back(t_row'{adc_item(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                              t_result'{8'h00, 1'b0, 10'd0, 1'b0, 1'b0}});
        rows.push_back(t_row'{adc_item(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023), 1'b1,
                              t_result'{8'h00, 1'b0, 10'd1023, 1'b1, 1'b0}});
        rows.push_back(t_row'{tick_item(4'h0, 4'h0, 1'b0), 1'b1,
                              t_result'{8'h01, 1'b1, 10'd1023, 1'b0, 1'b0}});
        rows.push_back(t_row'{tick_item(4'h0, 4'hF, 1'b0), 1'b1,
                              t_result'{8'h01, 1'b0, 10'd1023, 1'b0, 1'b1}});
        rows.push_back(t_row'{tick_item(4'hF, 4'h0, 1'b1), 1'b1,
                              t_result'{8'h02, 1'b1, 10'd1023, 1'b0, 1'b0}});
        rows.push_back(t_row'{tick_item(4'h0, 4'hF, 1'b1), 1'b0, none});
        rows.push_back(t_row'{tick_item(4'hF, 4'h0, 1'b0), 1'b0, none});
        repeat (6) rows.push_back(t_row'{tick_item(4'h0, 4'h0, 1'b0), 1'b0, none});
        rows.push_back(t_row'{adc_item(1020, 1020, 1020, 1020, 1020, 1020, 1020, 1020),
                              1'b0, none});
        rows.push_back(t_row'{adc_item(3, 3, 3, 3, 3, 3, 3, 3), 1'b0, none});
        rows.push_back(t_row'{adc_item(512, 512, 512, 512, 512, 512, 512, 512), 1'b0, none});
        rows.push_back(t_row'{adc_item(516, 516, 516, 516, 516, 516, 516, 516), 1'b0, none});
        rows.push_back(t_row'{adc_item(517, 517, 517, 517, 517, 517, 517, 517), 1'b0, none});
        rows.push_back(t_row'{adc_item(1023, 0, 1, 2, 3, 4, 5, 6), 1'b0, none});
        rows.push_back(t_row'{adc_item(300, 300, 300, 300, 300, 300, 300, 300), 1'b0, none});
        rows.push_back(t_row'{tick_item(4'h0, 4'h0, 1'b0), 1'b0, none});
        rows.push_back(t_row'{tick_item(4'h0, 4'h8, 1'b0), 1'b0, none});
        rows.push_back(t_row'{tick_item(4'h0, 4'h0, 1'b0), 1'b0, none});
        rows.push_back(t_row'{adc_item(1018, 1018, 1018, 1018, 1018, 1018, 1018, 1018),
                              1'b0, none});

        foreach (rows[k]) begin
            sender_pause();
            offer(rows[k].item, rows[k].typed, rows[k].want);
        end

        windows = '{0, 1023, 1, $urandom_range(2, 40), $urandom_range(0, 1023), 5};
        for (int p = 0; p < PHASES; p++) begin
            i_in_valid <= 1'b0;
            wait (beats_out == beats_in);
            write_window(windows[p]);
            if (p == 1) begin
                hold_armed <= 1'b1;
            end
            calm = (p == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sender_pause();
                offer(random_item(), 1'b0, none);
            end
        end

        i_in_valid <= 1'b0;
        wait (beats_out == beats_in);
        repeat (8) @(posedge i_clk);
        if (scan_queue.size() != 0) begin
            flag_error($sformatf("%0d expected results never arrived.", scan_queue.size()));
        end

        $display("Sent %0d beats over %0d window settings; checked %0d results.",
                 beats_in, PHASES + 1, beats_out);
        $display("Saw %0d LED steps, %0d voltage updates, %0d frozen results, %0d errors.",
                 n_steps, n_volt_changes, n_frozen, errors);
        if (errors == 0) begin
            $display("[potentiometer_paced_led_scanner] OK");
        end else begin
            $display("[potentiometer_paced_led_scanner] ERROR");
        end
        $finish;
    end

endmodule
